@@ hdl/psh_pkg.sv @@
// ----------------------------------------------------------------------------
// psh_pkg: shared types and codes for the profile sample hash counter
// Command and status codes, table entry layout and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package psh_pkg;

  // Default number of table slots
  localparam int TABLE_SIZE_DEF = 256;

  // Field widths
  localparam int CMD_W    = 2;
  localparam int KEY_W    = 64;
  localparam int RSLOT_W  = 8;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 8;
  localparam int COUNT_W  = 32;

  // Request commands (the spare code behaves as a read)
  localparam logic [CMD_W-1:0] CMD_RECORD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SPARE  = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_RECORDED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OVERWRITE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO_KEY  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SUSPENDED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_READ      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd5;

  // One table slot
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
  } entry_t;

  // Controller states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_REDUCE,
    S_PROBE,
    S_CHECK,
    S_RD_ADDR,
    S_RD_DATA,
    S_RESULT
  } state_t;

endpackage

`default_nettype wire

@@ hdl/profile_sample_hash_counter_unit.sv @@
// ----------------------------------------------------------------------------
// profile_sample_hash_counter_unit: sample count table with linear probing
// Counts samples keyed by a 64-bit stage mask in an open-addressed table
// held in one synchronous RAM; also reads one slot or clears the table.
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata                                    tuser
//  s_*      in   stage_key[63:0], read_slot[71:64]        cmd[1:0], suspended[2]
//  m_*      out  slot[7:0], slot_key[71:8], count[103:72] status[2:0]
//
//  One request at a time. A record runs the key modulo (HASH and REDUCE
//  per 16-bit digit), then PROBE and CHECK per probed slot (registered RAM
//  read), 1 to TABLE_SIZE+1 probes, then RESULT to post the result.
//  Read: RD_ADDR, RD_DATA, RESULT (RESULT alone for a slot past the table).
//  Ignored sample: RESULT alone. Clear: a sweep of every slot, then RESULT.
//  After reset the RAM is swept to zero; s_tready stays low meanwhile.
//  A stalled result holds the block in its last state.
//
`default_nettype none

module profile_sample_hash_counter_unit
  import psh_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  // request: stage_key[63:0], read_slot[71:64]
  input  wire logic [71:0]   s_tdata,
  // request: cmd[1:0], suspended[2]
  input  wire logic [2:0]    s_tuser,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  // result: slot[7:0], slot_key[71:8], slot_count[103:72]
  output logic [103:0]       m_tdata,
  // result: status[2:0]
  output logic [2:0]         m_tuser,
  output logic               m_tvalid,
  input  wire logic          m_tready
);

  localparam int IW = $clog2(TABLE_SIZE);   // slot index width
  localparam int SW = IW + 1;               // probe step count width
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SIZE - 1);
  localparam logic [SW-1:0] ALL_STEPS = SW'(TABLE_SIZE);
  localparam logic [16:0]   SIZE_EXT = 17'(TABLE_SIZE);
  // home slot modulus and its truncated reciprocal (2^32 / modulus)
  localparam logic [15:0]   HASH_MOD   = 16'(TABLE_SIZE - 1);
  localparam logic [31:0]   HASH_RECIP = 32'((64'd1 << 32) / 64'(TABLE_SIZE - 1));

  // Request fields
  logic [KEY_W-1:0]   in_key;
  logic [RSLOT_W-1:0] in_rslot;
  logic [CMD_W-1:0]   in_cmd;
  logic               in_susp;
  assign in_key   = s_tdata[63:0];
  assign in_rslot = s_tdata[71:64];
  assign in_cmd   = s_tuser[1:0];
  assign in_susp  = s_tuser[2];

  // State and datapath registers
  state_t state, state_next;
  logic              clr_report;
  logic [IW-1:0]     clr_idx;
  logic [KEY_W-1:0]  req_key;
  logic [KEY_W-1:0]  key_sh;
  logic [1:0]        dig_cnt;
  logic [15:0]       rem;
  logic [15:0]       quo;
  logic [IW-1:0]     h;
  logic [SW-1:0]     steps;
  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]   res_slot;
  logic [KEY_W-1:0]    res_key;
  logic [COUNT_W-1:0]  res_count;

  // Table RAM
  entry_t          mem [TABLE_SIZE];
  entry_t          mem_rdata;
  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  entry_t          mem_wdata;

  logic s_accept;
  assign s_accept = s_tvalid && s_tready;

  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  // Read decode
  logic [16:0] rslot_ext;
  logic        rslot_ok;
  assign rslot_ext = 17'(in_rslot);
  assign rslot_ok  = rslot_ext < SIZE_EXT;

  // Key modulo, one 16-bit digit per HASH/REDUCE state pair, high digit first:
  // quotient estimate by reciprocal multiply (low by at most one),
  // then multiply back, subtract and one correcting subtract
  logic [31:0] hash_t;
  logic [63:0] hash_prod;
  logic [31:0] hash_qm;
  logic [31:0] hash_diff;
  logic [15:0] rem_next;
  assign hash_t    = {rem, key_sh[KEY_W-1 -: 16]};
  assign hash_prod = 64'(hash_t) * 64'(HASH_RECIP);
  assign hash_qm   = 32'(quo) * 32'(HASH_MOD);
  assign hash_diff = hash_t - hash_qm;
  always_comb begin
    if (hash_diff >= 32'(HASH_MOD)) begin
      rem_next = 16'(hash_diff - 32'(HASH_MOD));
    end else begin
      rem_next = hash_diff[15:0];
    end
  end

  // Probe check
  logic              probe_hit;
  logic              probe_full;
  logic [COUNT_W-1:0] count_inc;
  assign probe_full = steps == ALL_STEPS;
  assign probe_hit  = probe_full || (mem_rdata.key == req_key) ||
                      (mem_rdata.key == '0);
  assign count_inc  = (mem_rdata.count == '1) ? mem_rdata.count
                                              : mem_rdata.count + 1'b1;

  logic [16:0] h_ext;
  assign h_ext = 17'(h);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_idx == LAST_IDX) begin
          state_next = clr_report ? S_RESULT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          if (in_cmd == CMD_CLEAR) begin
            state_next = S_CLEAR;
          end else if (in_cmd != CMD_RECORD) begin
            state_next = rslot_ok ? S_RD_ADDR : S_RESULT;
          end else if (in_susp || in_key == '0) begin
            state_next = S_RESULT;
          end else begin
            state_next = S_HASH;
          end
        end
      end
      S_HASH:    state_next = S_REDUCE;
      S_REDUCE: begin
        state_next = (dig_cnt == '0) ? S_PROBE : S_HASH;
      end
      S_PROBE:   state_next = S_CHECK;
      S_CHECK:   state_next = probe_hit ? S_RESULT : S_PROBE;
      S_RD_ADDR: state_next = S_RD_DATA;
      S_RD_DATA: state_next = S_RESULT;
      S_RESULT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    s_tready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = h;
    mem_wdata = '{key: req_key, count: count_inc};
    unique case (state)
      S_IDLE:  s_tready = 1'b1;
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
        mem_wdata = '0;
      end
      S_CHECK: mem_we = probe_hit;
      default: ;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Clear sweep control
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx    <= '0;
      clr_report <= 1'b0;
    end else if (state == S_CLEAR) begin
      clr_idx <= (clr_idx == LAST_IDX) ? '0 : clr_idx + 1'b1;
    end else if (s_accept) begin
      clr_report <= 1'b1;
    end
  end

  // RAM: one write port, one registered read port at the probe index
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[h];
  end

  // Datapath: hashing, probe walk and result capture
  always_ff @(posedge clk) begin
    unique case (state)
      S_CLEAR: begin
        res_status <= ST_CLEARED;
        res_slot   <= '0;
        res_key    <= '0;
        res_count  <= '0;
      end
      S_IDLE: begin
        req_key <= in_key;
        key_sh  <= in_key;
        dig_cnt <= 2'd3;
        rem     <= '0;
        steps   <= '0;
        h       <= rslot_ext[IW-1:0];
        res_key   <= '0;
        res_count <= '0;
        if (in_cmd != CMD_RECORD) begin
          res_status <= ST_READ;
          res_slot   <= in_rslot;
        end else if (in_susp) begin
          res_status <= ST_SUSPENDED;
          res_slot   <= '0;
        end else begin
          res_status <= ST_ZERO_KEY;
          res_slot   <= '0;
        end
      end
      S_HASH: begin
        quo <= hash_prod[47:32];
      end
      S_REDUCE: begin
        key_sh  <= {key_sh[KEY_W-17:0], 16'h0000};
        dig_cnt <= dig_cnt - 1'b1;
        rem     <= rem_next;
        h       <= rem_next[IW-1:0];
      end
      S_CHECK: begin
        if (probe_hit) begin
          res_status <= probe_full ? ST_OVERWRITE : ST_RECORDED;
          res_slot   <= h_ext[7:0];
          res_key    <= req_key;
          res_count  <= count_inc;
        end else begin
          h     <= (h == LAST_IDX) ? '0 : h + 1'b1;
          steps <= steps + 1'b1;
        end
      end
      S_RD_DATA: begin
        res_key   <= mem_rdata.key;
        res_count <= mem_rdata.count;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_RESULT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESULT && out_free) begin
      m_tdata <= {res_count, res_key, res_slot};
      m_tuser <= res_status;
    end
  end

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> !s_tready)
    else $error("request taken while previous request in flight");

  a_record_nonzero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == ST_RECORDED || m_tuser == ST_OVERWRITE)) |->
    (m_tdata[71:8] != '0 && m_tdata[103:72] != '0))
    else $error("recorded slot with zero key or zero count");

  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> (steps <= ALL_STEPS))
    else $error("probe walk ran past one table pass");

  a_no_write_on_accept: assert property (@(posedge clk) disable iff (rst)
    s_accept |-> !mem_we)
    else $error("table write while idle");

endmodule

`default_nettype wire
